### rtl/pfp_pkg.sv
package pfp_pkg;

   // field and datapath widths
   localparam int CoordW   = 24;
   localparam int DiffW    = 25;
   localparam int ProdW    = 50;
   localparam int NormalW  = 51;
   localparam int MagW     = 50;
   localparam int HalfW    = 25;
   localparam int DotLoW   = 26;
   localparam int DotHiW   = NormalW - DotLoW;
   localparam int DotW     = 77;
   localparam int DistMagW = 76;
   localparam int SqW      = 100;
   localparam int SumSqW   = 102;
   localparam int RootW    = 52;
   localparam int RadW     = 2 * RootW;
   localparam int SqrtRemW = RootW + 4;
   localparam int DivW     = RootW + 1;
   localparam int QuotW    = 32;
   localparam int DivRemW  = DivW + QuotW + 1;
   localparam int UnitW    = 32;
   localparam int DistW    = 24;
   localparam int CsrW     = 32;

   // divider lanes
   localparam int Lanes    = 4;
   localparam int LaneX    = 0;
   localparam int LaneY    = 1;
   localparam int LaneZ    = 2;
   localparam int LaneDist = 3;

   localparam logic [CsrW-1:0] MinNormReset = 32'd42950;

   typedef struct packed {
      logic [MagW-1:0]     mag_x;
      logic [MagW-1:0]     mag_y;
      logic [MagW-1:0]     mag_z;
      logic                neg_x;
      logic                neg_y;
      logic                neg_z;
      logic                neg_d;
      logic [DistMagW-1:0] dist_mag;
   } geom_type;

endpackage

### rtl/pfp_setup.sv
module pfp_setup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic signed [pfp_pkg::CoordW-1:0] a_x,
   input  logic signed [pfp_pkg::CoordW-1:0] a_y,
   input  logic signed [pfp_pkg::CoordW-1:0] a_z,
   input  logic signed [pfp_pkg::CoordW-1:0] b_x,
   input  logic signed [pfp_pkg::CoordW-1:0] b_y,
   input  logic signed [pfp_pkg::CoordW-1:0] b_z,
   input  logic signed [pfp_pkg::CoordW-1:0] c_x,
   input  logic signed [pfp_pkg::CoordW-1:0] c_y,
   input  logic signed [pfp_pkg::CoordW-1:0] c_z,
   output logic                              out_valid,
   output pfp_pkg::geom_type                 geom,
   output logic [pfp_pkg::SumSqW-1:0]        sum_sq
);

   // stage 1: edge vectors
   logic                              v1_ff;
   logic signed [pfp_pkg::DiffW-1:0]  u_ff [0:2];
   logic signed [pfp_pkg::DiffW-1:0]  w_ff [0:2];
   logic signed [pfp_pkg::CoordW-1:0] a1_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0]  <= pfp_pkg::DiffW'(b_x) - pfp_pkg::DiffW'(a_x);
         u_ff[1]  <= pfp_pkg::DiffW'(b_y) - pfp_pkg::DiffW'(a_y);
         u_ff[2]  <= pfp_pkg::DiffW'(b_z) - pfp_pkg::DiffW'(a_z);
         w_ff[0]  <= pfp_pkg::DiffW'(c_x) - pfp_pkg::DiffW'(a_x);
         w_ff[1]  <= pfp_pkg::DiffW'(c_y) - pfp_pkg::DiffW'(a_y);
         w_ff[2]  <= pfp_pkg::DiffW'(c_z) - pfp_pkg::DiffW'(a_z);
         a1_ff[0] <= a_x;
         a1_ff[1] <= a_y;
         a1_ff[2] <= a_z;
      end
   end

   // stage 2: cross product terms
   logic                              v2_ff;
   logic signed [pfp_pkg::ProdW-1:0]  pp_ff [0:2];
   logic signed [pfp_pkg::ProdW-1:0]  pm_ff [0:2];
   logic signed [pfp_pkg::CoordW-1:0] a2_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= u_ff[1] * w_ff[2];
         pm_ff[0] <= w_ff[1] * u_ff[2];
         pp_ff[1] <= u_ff[2] * w_ff[0];
         pm_ff[1] <= w_ff[2] * u_ff[0];
         pp_ff[2] <= u_ff[0] * w_ff[1];
         pm_ff[2] <= w_ff[0] * u_ff[1];
         a2_ff    <= a1_ff;
      end
   end

   // stage 3: normal
   logic                               v3_ff;
   logic signed [pfp_pkg::NormalW-1:0] n_ff [0:2];
   logic signed [pfp_pkg::CoordW-1:0]  a3_ff [0:2];

   // stages 4 and 5 per axis: split products for dot and square
   logic                                v4_ff;
   logic                                v5_ff;
   logic [pfp_pkg::MagW-1:0]            mag4_ff [0:2];
   logic [pfp_pkg::MagW-1:0]            mag5_ff [0:2];
   logic [2:0]                          neg4_ff;
   logic [2:0]                          neg5_ff;
   logic signed [pfp_pkg::DotW-1:0]     dp_ff [0:2];
   logic [pfp_pkg::SqW-1:0]             sq_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      logic [pfp_pkg::MagW-1:0]                    mag_in;
      logic signed [pfp_pkg::DotLoW+pfp_pkg::CoordW:0]   dlo_ff;
      logic signed [pfp_pkg::DotHiW+pfp_pkg::CoordW-1:0] dhi_ff;
      logic [2*pfp_pkg::HalfW-1:0]                 hh_ff;
      logic [2*pfp_pkg::HalfW-1:0]                 hl_ff;
      logic [2*pfp_pkg::HalfW-1:0]                 ll_ff;

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[g] <= pfp_pkg::NormalW'(pp_ff[g]) - pfp_pkg::NormalW'(pm_ff[g]);
         end
      end

      always_comb begin
         mag_in = n_ff[g][pfp_pkg::NormalW-1] ? pfp_pkg::MagW'(-n_ff[g])
                                               : pfp_pkg::MagW'(n_ff[g]);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dlo_ff     <= $signed({1'b0, n_ff[g][pfp_pkg::DotLoW-1:0]}) * a3_ff[g];
            dhi_ff     <= $signed(n_ff[g][pfp_pkg::NormalW-1:pfp_pkg::DotLoW]) * a3_ff[g];
            hh_ff      <= mag_in[pfp_pkg::MagW-1:pfp_pkg::HalfW]
                          * mag_in[pfp_pkg::MagW-1:pfp_pkg::HalfW];
            hl_ff      <= mag_in[pfp_pkg::MagW-1:pfp_pkg::HalfW]
                          * mag_in[pfp_pkg::HalfW-1:0];
            ll_ff      <= mag_in[pfp_pkg::HalfW-1:0] * mag_in[pfp_pkg::HalfW-1:0];
            mag4_ff[g] <= mag_in;
            neg4_ff[g] <= n_ff[g][pfp_pkg::NormalW-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dp_ff[g]   <= (pfp_pkg::DotW'(dhi_ff) <<< pfp_pkg::DotLoW)
                          + pfp_pkg::DotW'(dlo_ff);
            sq_ff[g]   <= (pfp_pkg::SqW'(hh_ff) << (2 * pfp_pkg::HalfW))
                          + (pfp_pkg::SqW'(hl_ff) << (pfp_pkg::HalfW + 1))
                          + pfp_pkg::SqW'(ll_ff);
            mag5_ff[g] <= mag4_ff[g];
            neg5_ff[g] <= neg4_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) a3_ff <= a2_ff;
   end

   // stage 6: sums
   logic                            v6_ff;
   logic signed [pfp_pkg::DotW-1:0] d_ff;
   logic [pfp_pkg::SumSqW-1:0]      s6_ff;
   logic [pfp_pkg::MagW-1:0]        mag6_ff [0:2];
   logic [2:0]                      neg6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= dp_ff[0] + dp_ff[1] + dp_ff[2];
         s6_ff   <= pfp_pkg::SumSqW'(sq_ff[0]) + pfp_pkg::SumSqW'(sq_ff[1])
                    + pfp_pkg::SumSqW'(sq_ff[2]);
         mag6_ff <= mag5_ff;
         neg6_ff <= neg5_ff;
      end
   end

   // stage 7: distance magnitude and sign
   logic                       v7_ff;
   pfp_pkg::geom_type          geom_ff;
   pfp_pkg::geom_type          geom_in;
   logic [pfp_pkg::SumSqW-1:0] s7_ff;

   always_comb begin
      geom_in.mag_x    = mag6_ff[0];
      geom_in.mag_y    = mag6_ff[1];
      geom_in.mag_z    = mag6_ff[2];
      geom_in.neg_x    = neg6_ff[0];
      geom_in.neg_y    = neg6_ff[1];
      geom_in.neg_z    = neg6_ff[2];
      geom_in.neg_d    = d_ff[pfp_pkg::DotW-1];
      geom_in.dist_mag = d_ff[pfp_pkg::DotW-1] ? pfp_pkg::DistMagW'(-d_ff)
                                                : pfp_pkg::DistMagW'(d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geom_ff <= geom_in;
         s7_ff   <= s6_ff;
      end
   end

   assign out_valid = v7_ff;
   assign geom      = geom_ff;
   assign sum_sq    = s7_ff;

endmodule

### rtl/pfp_sqrt.sv
module pfp_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  pfp_pkg::geom_type           in_geom,
   input  logic [pfp_pkg::SumSqW-1:0]  sum_sq,
   output logic                        out_valid,
   output pfp_pkg::geom_type           out_geom,
   output logic [pfp_pkg::RootW-1:0]   root
);

   localparam int Steps = pfp_pkg::RootW;

   logic                          v_ff    [0:Steps-1];
   pfp_pkg::geom_type             geom_ff [0:Steps-1];
   logic [pfp_pkg::RadW-1:0]      rad_ff  [0:Steps-1];
   logic [pfp_pkg::RootW-1:0]     root_ff [0:Steps-1];
   logic [pfp_pkg::SqrtRemW-1:0]  rem_ff  [0:Steps-1];

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic                          v_s;
      pfp_pkg::geom_type             geom_s;
      logic [pfp_pkg::RadW-1:0]      rad_s;
      logic [pfp_pkg::RootW-1:0]     root_s;
      logic [pfp_pkg::SqrtRemW-1:0]  rem_s;
      logic [pfp_pkg::SqrtRemW-1:0]  rem_sh;
      logic [pfp_pkg::SqrtRemW-1:0]  trial;
      logic [pfp_pkg::SqrtRemW-1:0]  rem_in;
      logic [pfp_pkg::RootW-1:0]     root_in;

      if (k == 0) begin : g_first
         assign v_s    = in_valid;
         assign geom_s = in_geom;
         assign rad_s  = pfp_pkg::RadW'(sum_sq);
         assign root_s = '0;
         assign rem_s  = '0;
      end else begin : g_next
         assign v_s    = v_ff[k-1];
         assign geom_s = geom_ff[k-1];
         assign rad_s  = rad_ff[k-1];
         assign root_s = root_ff[k-1];
         assign rem_s  = rem_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_s[pfp_pkg::SqrtRemW-3:0], rad_s[pfp_pkg::RadW-1 -: 2]};
         trial  = {2'b00, root_s, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_s[pfp_pkg::RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_s[pfp_pkg::RootW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else if (adv) v_ff[k] <= v_s;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            geom_ff[k] <= geom_s;
            rad_ff[k]  <= rad_s << 2;
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
         end
      end
   end

   assign out_valid = v_ff[Steps-1];
   assign out_geom  = geom_ff[Steps-1];
   assign root      = root_ff[Steps-1];

endmodule

### rtl/pfp_div.sv
module pfp_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  pfp_pkg::geom_type                  in_geom,
   input  logic [pfp_pkg::RootW-1:0]          root,
   input  logic [pfp_pkg::CsrW-1:0]           min_norm,
   output logic                               out_valid,
   output logic signed [pfp_pkg::UnitW-1:0]   unit_x,
   output logic signed [pfp_pkg::UnitW-1:0]   unit_y,
   output logic signed [pfp_pkg::UnitW-1:0]   unit_z,
   output logic [pfp_pkg::DistW-1:0]          origin_distance,
   output logic                               degenerate
);

   localparam int Steps = pfp_pkg::QuotW;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tag_type;

   // entry: numerators with rounding term, divisor 2*root
   logic                         ev_ff;
   tag_type                      etag_ff;
   logic [pfp_pkg::DivW-1:0]     eden_ff;
   logic [pfp_pkg::DivRemW-1:0]  enum_ff [0:pfp_pkg::Lanes-1];
   tag_type                      etag_in;

   always_comb begin
      etag_in.neg   = {in_geom.neg_z ^ in_geom.neg_d,
                       in_geom.neg_y ^ in_geom.neg_d,
                       in_geom.neg_x ^ in_geom.neg_d};
      etag_in.degen = root <= pfp_pkg::RootW'(min_norm);
   end

   always_ff @(posedge clock) begin
      if (reset) ev_ff <= 1'b0;
      else if (adv) ev_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         etag_ff <= etag_in;
         eden_ff <= {root, 1'b0};
         enum_ff[pfp_pkg::LaneX] <= (pfp_pkg::DivRemW'(in_geom.mag_x) << (pfp_pkg::UnitW - 1))
                                    + pfp_pkg::DivRemW'(root);
         enum_ff[pfp_pkg::LaneY] <= (pfp_pkg::DivRemW'(in_geom.mag_y) << (pfp_pkg::UnitW - 1))
                                    + pfp_pkg::DivRemW'(root);
         enum_ff[pfp_pkg::LaneZ] <= (pfp_pkg::DivRemW'(in_geom.mag_z) << (pfp_pkg::UnitW - 1))
                                    + pfp_pkg::DivRemW'(root);
         enum_ff[pfp_pkg::LaneDist] <= (pfp_pkg::DivRemW'(in_geom.dist_mag) << 1)
                                       + pfp_pkg::DivRemW'(root);
      end
   end

   // restoring division, one quotient bit per stage in each lane
   logic                         v_ff    [0:Steps-1];
   tag_type                      tag_ff  [0:Steps-1];
   logic                         ovf_ff  [0:Steps-1];
   logic [pfp_pkg::DivW-1:0]     den_ff  [0:Steps-1];
   logic [pfp_pkg::DivRemW-1:0]  rem_ff  [0:Steps-1][0:pfp_pkg::Lanes-1];
   logic [pfp_pkg::QuotW-1:0]    quot_ff [0:Steps-1][0:pfp_pkg::Lanes-1];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      localparam int Sh = Steps - 1 - k;
      logic                         v_s;
      tag_type                      tag_s;
      logic                         ovf_s;
      logic                         ovf_in;
      logic [pfp_pkg::DivW-1:0]     den_s;
      logic [pfp_pkg::DivRemW-1:0]  rem_s  [0:pfp_pkg::Lanes-1];
      logic [pfp_pkg::QuotW-1:0]    quot_s [0:pfp_pkg::Lanes-1];
      logic [pfp_pkg::DivRemW-1:0]  dsh;

      if (k == 0) begin : g_first
         assign v_s   = ev_ff;
         assign tag_s = etag_ff;
         assign den_s = eden_ff;
         assign ovf_s = 1'b0;
         for (genvar l = 0; l < pfp_pkg::Lanes; l++) begin : g_ln
            assign rem_s[l]  = enum_ff[l];
            assign quot_s[l] = '0;
         end
         // quotient too wide for the bit range of the pipe
         assign ovf_in = enum_ff[pfp_pkg::LaneDist]
                         >= (pfp_pkg::DivRemW'(eden_ff) << pfp_pkg::QuotW);
      end else begin : g_next
         assign v_s    = v_ff[k-1];
         assign tag_s  = tag_ff[k-1];
         assign den_s  = den_ff[k-1];
         assign ovf_s  = ovf_ff[k-1];
         assign ovf_in = ovf_s;
         for (genvar l = 0; l < pfp_pkg::Lanes; l++) begin : g_ln
            assign rem_s[l]  = rem_ff[k-1][l];
            assign quot_s[l] = quot_ff[k-1][l];
         end
      end

      assign dsh = pfp_pkg::DivRemW'(den_s) << Sh;

      for (genvar l = 0; l < pfp_pkg::Lanes; l++) begin : g_lane
         logic [pfp_pkg::DivRemW:0] diff;
         logic                      take;

         always_comb begin
            diff = {1'b0, rem_s[l]} - {1'b0, dsh};
            take = !diff[pfp_pkg::DivRemW];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l]  <= take ? diff[pfp_pkg::DivRemW-1:0] : rem_s[l];
               quot_ff[k][l] <= {quot_s[l][pfp_pkg::QuotW-2:0], take};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else if (adv) v_ff[k] <= v_s;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k] <= tag_s;
            den_ff[k] <= den_s;
            ovf_ff[k] <= ovf_in;
         end
      end
   end

   // output word: sign, saturate, zero on degenerate
   logic                              ov_ff;
   logic signed [pfp_pkg::UnitW-1:0]  ux_ff, uy_ff, uz_ff;
   logic signed [pfp_pkg::UnitW-1:0]  ux_in, uy_in, uz_in;
   logic [pfp_pkg::DistW-1:0]         dist_ff, dist_in;
   logic                              degen_ff;
   tag_type                           ftag;
   logic                              sat;

   function automatic logic signed [pfp_pkg::UnitW-1:0] apply_sign(
      input logic [pfp_pkg::QuotW-1:0] q,
      input logic                      neg,
      input logic                      zero
   );
      logic signed [pfp_pkg::UnitW-1:0] m;
      m = $signed({1'b0, q[pfp_pkg::UnitW-2:0]});
      if (zero) return '0;
      return neg ? -m : m;
   endfunction

   always_comb begin
      ftag  = tag_ff[Steps-1];
      sat   = ovf_ff[Steps-1]
              || (|quot_ff[Steps-1][pfp_pkg::LaneDist][pfp_pkg::QuotW-1:pfp_pkg::DistW]);
      ux_in = apply_sign(quot_ff[Steps-1][pfp_pkg::LaneX], ftag.neg[0], ftag.degen);
      uy_in = apply_sign(quot_ff[Steps-1][pfp_pkg::LaneY], ftag.neg[1], ftag.degen);
      uz_in = apply_sign(quot_ff[Steps-1][pfp_pkg::LaneZ], ftag.neg[2], ftag.degen);
      if (ftag.degen) dist_in = '0;
      else if (sat) dist_in = '1;
      else dist_in = quot_ff[Steps-1][pfp_pkg::LaneDist][pfp_pkg::DistW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= v_ff[Steps-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         uz_ff    <= uz_in;
         dist_ff  <= dist_in;
         degen_ff <= ftag.degen;
      end
   end

   assign out_valid       = ov_ff;
   assign unit_x          = ux_ff;
   assign unit_y          = uy_ff;
   assign unit_z          = uz_ff;
   assign origin_distance = dist_ff;
   assign degenerate      = degen_ff;

endmodule

### rtl/plane_from_three_points_core.sv
// Plane through three points, Hessian normal form.
// Request channel (req_*): one word carries three points a, b, c in signed
// Q7.16; taken at a rising edge with req_valid high and req_stall low.
// Response channel (rsp_*): one word per request, in order: unit normal in
// signed Q1.30, origin distance in unsigned Q8.16 (saturates at all ones),
// and a degenerate flag (normal and distance zero) when the cross product
// length is not above the csr minimum.
// CSR: csr_wr_en writes csr_wr_data into the minimum length (units 2^-32).
// Pipeline: 93 register stages between the edge that takes a word and rsp_*.
// Throughput: one word per cycle while the pipe is not frozen. The stage count is set
// by the 52-stage square root (one root bit per stage) and the 32-stage
// divider (one quotient bit per stage, four lanes side by side).
// Reset clears every valid bit and loads the minimum length default; the
// block takes a word in the first cycle after reset.
// When rsp_stall holds a valid response, the whole pipe freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
module plane_from_three_points_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_a_x,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_a_y,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_a_z,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_b_x,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_b_y,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_b_z,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_c_x,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_c_y,
   input  logic signed [pfp_pkg::CoordW-1:0]  req_c_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pfp_pkg::UnitW-1:0]   rsp_unit_x,
   output logic signed [pfp_pkg::UnitW-1:0]   rsp_unit_y,
   output logic signed [pfp_pkg::UnitW-1:0]   rsp_unit_z,
   output logic [pfp_pkg::DistW-1:0]          rsp_origin_distance,
   output logic                               rsp_degenerate,
   input  logic                               csr_wr_en,
   input  logic [pfp_pkg::CsrW-1:0]           csr_wr_data
);

   // Freeze every stage while a finished word waits on a stalled receiver.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Minimum accepted cross product length; the user changes it only while idle, the block does not enforce this.
   logic [pfp_pkg::CsrW-1:0] min_norm_ff;

   always_ff @(posedge clock) begin
      if (reset) min_norm_ff <= pfp_pkg::MinNormReset;
      else if (csr_wr_en) min_norm_ff <= csr_wr_data;
   end

   // Front end: edges, cross product, exact dot product, squared length.
   logic                       setup_valid;
   pfp_pkg::geom_type          setup_geom;
   logic [pfp_pkg::SumSqW-1:0] setup_sum_sq;

   pfp_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_z       (req_a_z),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .b_z       (req_b_z),
      .c_x       (req_c_x),
      .c_y       (req_c_y),
      .c_z       (req_c_z),
      .out_valid (setup_valid),
      .geom      (setup_geom),
      .sum_sq    (setup_sum_sq)
   );

   // Floor of the square root of the squared length.
   logic                      sqrt_valid;
   pfp_pkg::geom_type         sqrt_geom;
   logic [pfp_pkg::RootW-1:0] sqrt_root;

   pfp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (setup_valid),
      .in_geom   (setup_geom),
      .sum_sq    (setup_sum_sq),
      .out_valid (sqrt_valid),
      .out_geom  (sqrt_geom),
      .root      (sqrt_root)
   );

   // Rounded divides by the length, sign flip, degenerate and saturation.
   // Its last stage is the response register.
   pfp_div u_div (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (sqrt_valid),
      .in_geom         (sqrt_geom),
      .root            (sqrt_root),
      .min_norm        (min_norm_ff),
      .out_valid       (rsp_valid),
      .unit_x          (rsp_unit_x),
      .unit_y          (rsp_unit_y),
      .unit_z          (rsp_unit_z),
      .origin_distance (rsp_origin_distance),
      .degenerate      (rsp_degenerate)
   );

`ifndef ASSERT_OFF
   // degenerate words carry an all-zero payload
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0
         && rsp_origin_distance == '0)
      else $error("degenerate word with nonzero payload");

   // a real plane has a nonzero normal
   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_unit_x != '0 || rsp_unit_y != '0 || rsp_unit_z != '0)
      else $error("zero normal on a valid plane");

   // unit components never exceed one in magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_unit_x <= 32'sh40000000 && rsp_unit_x >= -32'sh40000000
         && rsp_unit_y <= 32'sh40000000 && rsp_unit_y >= -32'sh40000000
         && rsp_unit_z <= 32'sh40000000 && rsp_unit_z >= -32'sh40000000)
      else $error("unit component out of range");

   // a held response freezes the request side too
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");
`endif

endmodule
